// File: sv/ins_pkg.sv
// shared types and constants for the insertion sorter
package ins_pkg;

   localparam int DATA_W = 32;

   // control broadcast along the row of cells
   typedef struct packed {
      logic              insert;
      logic              drain;
      logic [DATA_W-1:0] value;
   } ins_ctrl_type;

endpackage

// File: sv/ins_cell.sv
// one compare-and-shift cell of the sorting row
module ins_cell (
   input  logic                                 clock,
   input  ins_pkg::ins_ctrl_type                ctrl,
   input  logic                                 occupied,
   input  logic signed [ins_pkg::DATA_W-1:0]    left_value,
   input  logic                                 left_greater,
   input  logic signed [ins_pkg::DATA_W-1:0]    right_value,
   output logic signed [ins_pkg::DATA_W-1:0]    value,
   output logic                                 greater
);

   logic signed [ins_pkg::DATA_W-1:0] value_ff;
   logic signed [ins_pkg::DATA_W-1:0] value_in;

   // an empty cell counts as larger than anything
   assign greater = !occupied || ($signed(value_ff) > $signed(ctrl.value));
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert && greater) begin
         // shift up from the left neighbour, or take the new value at the boundary
         value_in = left_greater ? left_value : $signed(ctrl.value);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: sv/insertion_sorter.sv
// top level of the streaming insertion sorter: a row of compare-and-shift cells
// Each input beat is inserted into the row in parallel: every cell compares the new
// value with its own entry at once, and the larger entries move up one cell, so req_ready
// stays high and one value a cycle is taken while a set is being collected. A beat with
// last_in set starts a drain: the row shifts down one cell per rsp beat, smallest value
// first, so a set of N stored values gives N result beats at one per cycle while
// rsp_ready is high; no input beat is taken during the drain. Values arriving with
// MAX_ITEMS entries held are dropped and rsp_overflow is set on every beat of that set.
module insertion_sorter #(
   parameter int MAX_ITEMS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ins_pkg::DATA_W-1:0]   req_value,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ins_pkg::DATA_W-1:0]   rsp_sorted_value,
   output logic                                rsp_last_out,
   output logic                                rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ITEMS);
   localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic             draining_ff, draining_in;

   logic                                req_fire, rsp_fire, full;
   ins_pkg::ins_ctrl_type               ctrl;
   logic signed [ins_pkg::DATA_W-1:0]   cell_value [MAX_ITEMS];
   logic                                cell_greater [MAX_ITEMS];
   logic                                occupied [MAX_ITEMS];

   assign req_ready = !draining_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = draining_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign full      = (count_ff == FULL_COUNT);

   assign ctrl.insert = req_fire && !full;
   assign ctrl.drain  = rsp_fire;
   assign ctrl.value  = req_value;

   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = (count_ff == ONE_COUNT);
   assign rsp_overflow     = dropped_ff;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [ins_pkg::DATA_W-1:0] left_value;
      logic                              left_greater;
      logic signed [ins_pkg::DATA_W-1:0] right_value;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_value   = req_value;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_value   = cell_value[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_end
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      ins_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (occupied[i]),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   always_comb begin
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      draining_in = draining_ff;
      if (req_fire) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + ONE_COUNT;
         end
         if (req_last_in) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_fire) begin
         count_in = count_ff - ONE_COUNT;
         // final beat of the set empties the row
         if (count_ff == ONE_COUNT) begin
            draining_in = 1'b0;
            dropped_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         draining_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         draining_ff <= draining_in;
      end
   end

endmodule

// File: dv/sorted_set_checker.sv
// checker for the insertion sorter: predicts each sorted set and compares every result beat
module sorted_set_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [ins_pkg::DATA_W-1:0]   req_value,
   input  logic                                req_last_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [ins_pkg::DATA_W-1:0]   rsp_sorted_value,
   input  logic                                rsp_last_out,
   input  logic                                rsp_overflow,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [ins_pkg::DATA_W-1:0] value;
      logic                              last;
      logic                              overflow;
   } sorted_beat_type;

   logic signed [ins_pkg::DATA_W-1:0] held_values[$];
   logic                              set_overflowed = 1'b0;
   sorted_beat_type                   expected_sorted[$];
   int                                failures = 0;
   int                                backlog = 0;

   assign mismatch_count = failures;
   assign outstanding    = backlog;

   function automatic void note_mismatch(input string text);
      failures++;
      if (failures <= 10)
         $display("%0t ns mismatch: %s", $time, text);
   endfunction

   // stable insertion: a new value goes after every held value that is not larger
   task automatic absorb_value(input logic signed [ins_pkg::DATA_W-1:0] v, input logic last);
      int              pos;
      sorted_beat_type beat;
      if (held_values.size() < CAPACITY) begin
         pos = 0;
         while (pos < held_values.size() && held_values[pos] <= v)
            pos++;
         held_values.insert(pos, v);
      end else begin
         set_overflowed = 1'b1;
      end
      if (last) begin
         foreach (held_values[k]) begin
            beat.value    = held_values[k];
            beat.last     = (k == held_values.size() - 1);
            beat.overflow = set_overflowed;
            expected_sorted.push_back(beat);
         end
         held_values.delete();
         set_overflowed = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      sorted_beat_type want;
      if (reset) begin
         held_values.delete();
         expected_sorted.delete();
         set_overflowed = 1'b0;
      end else begin
         if (req_valid && req_ready)
            absorb_value(req_value, req_last_in);
         if (rsp_valid && rsp_ready) begin
            if (expected_sorted.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing expected: value %0d last %0b ovf %0b",
                                       rsp_sorted_value, rsp_last_out, rsp_overflow));
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_sorted_value !== want.value || rsp_last_out !== want.last ||
                   rsp_overflow !== want.overflow)
                  note_mismatch($sformatf(
                     "expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                     want.value, want.last, want.overflow,
                     rsp_sorted_value, rsp_last_out, rsp_overflow));
            end
         end
      end
      backlog = expected_sorted.size();
   end

endmodule

// File: dv/testbench.sv
// top of the insertion sorter testbench: clock, reset, stimulus, watchdog and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 16;
   localparam int ITEM_TARGET   = 410;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 20;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [ins_pkg::DATA_W-1:0] req_value = '0;
   logic                              req_last_in = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [ins_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                              rsp_last_out;
   logic                              rsp_overflow;

   int mismatch_count;
   int outstanding;
   int items_sent = 0;
   int req_max_gap = 0;
   int rsp_max_gap = 0;
   int idle_cycles = 0;

   insertion_sorter #(.MAX_ITEMS(CAPACITY)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   sorted_set_checker #(.CAPACITY(CAPACITY)) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: a fresh stall of 0..rsp_max_gap cycles before each beat
   initial begin
      int gap;
      forever begin
         gap = $urandom_range(0, rsp_max_gap);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
      end
   end

   // no beat on either channel for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_value(input logic signed [ins_pkg::DATA_W-1:0] v, input logic last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_last_in <= last;
      @(posedge clock iff req_ready);
      items_sent++;
   endtask

   function automatic logic signed [ins_pkg::DATA_W-1:0] pick_value(input int style);
      case (style)
         0: pick_value = $urandom;
         // narrow range so equal values turn up often
         1: pick_value = $signed($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 3))
               0: pick_value = 32'sh8000_0000;
               1: pick_value = 32'sh7fff_ffff;
               2: pick_value = '0;
               default: pick_value = $urandom;
            endcase
         end
      endcase
   endfunction

   initial begin
      int set_len;
      int style;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: lone extremes, a mixed set, then a full list whose last value is dropped
      send_value(32'sh8000_0000, 1'b1);
      send_value(32'sh7fff_ffff, 1'b1);
      req_max_gap = 4;
      rsp_max_gap = 4;
      send_value(32'sh7fff_ffff, 1'b0);
      send_value(-32'sd1, 1'b0);
      send_value(32'sh8000_0000, 1'b0);
      send_value(32'sd1, 1'b0);
      send_value(-32'sd1, 1'b0);
      send_value(32'sh5555_5555, 1'b1);
      req_max_gap = 0;
      rsp_max_gap = 0;
      for (int k = 0; k <= CAPACITY; k++)
         send_value(32'sd1000 - k * 3, k == CAPACITY);

      while (items_sent < ITEM_TARGET) begin
         req_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
         rsp_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY - 1, CAPACITY + 4)
                                               : $urandom_range(1, 8);
         style = $urandom_range(0, 2);
         for (int k = 0; k < set_len; k++)
            send_value(pick_value(style), k == set_len - 1);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
sv/ins_pkg.sv
sv/ins_cell.sv
sv/insertion_sorter.sv
dv/sorted_set_checker.sv
dv/testbench.sv
